// ===== sv/r2a_pkg.sv =====
// ---------------------------------------------------------------------------
// r2a_pkg: shared constants and helpers for the radix to ASCII digit core
// Radix limits, division step size, queue depth and the digit to ASCII map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package r2a_pkg;

  localparam int VALUE_BITS_DEF = 32;    // default converted value width
  localparam int IN_VALUE_W     = 32;    // width of the value field on the port
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int STEP_BITS      = 8;     // quotient bits resolved per cycle
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_TOP    = 7'd90;  // 'Z'

  // 0..9 -> '0'..'9', 10..35 -> 'A'..'Z'; anything above clamps to 'Z'
  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < 6'd10) begin
      digit_char_of = CHAR_ZERO + d_ext;
    end else if (d < RADIX_MAX) begin
      digit_char_of = CHAR_LETTER + d_ext;
    end else begin
      digit_char_of = CHAR_TOP;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/r2a_front.sv =====
// ---------------------------------------------------------------------------
// r2a_front: input classification
// Takes a transaction, clamps the radix into 2..36, trims the value to
// VALUE_BITS and hands the item to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2a_front import r2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_VALUE_W-1:0] in_value,
  input  wire logic [RADIX_W-1:0]    in_radix,
  input  wire logic                  q_ready,
  output logic                       q_push,
  output logic [VALUE_BITS-1:0]      q_value,
  output logic [RADIX_W-1:0]         q_radix
);

  localparam int EXT_W = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  logic [EXT_W-1:0] value_ext;

  assign value_ext = EXT_W'(in_value);
  assign q_value   = value_ext[VALUE_BITS-1:0];

  always_comb begin
    if (in_radix < RADIX_MIN) begin
      q_radix = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      q_radix = RADIX_MAX;
    end else begin
      q_radix = in_radix;
    end
  end

  assign in_tready = q_ready;
  assign q_push    = in_tvalid & q_ready;

endmodule

`default_nettype wire

// ===== sv/r2a_queue.sv =====
// ---------------------------------------------------------------------------
// r2a_queue: short item queue between front and back
// Small register FIFO so the input side and the converter stall apart.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2a_queue import r2a_pkg::*; #(
  parameter int DATA_W = VALUE_BITS_DEF + RADIX_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] din,
  output logic                   push_ready,
  input  wire logic              pop,
  output logic                   pop_valid,
  output logic [DATA_W-1:0]      dout
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign dout       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/r2a_back.sv =====
// ---------------------------------------------------------------------------
// r2a_back: digit converter
// Divides the value by the radix over and over, STEP_BITS quotient bits per
// cycle, stacks the remainders as ASCII and plays them back MSD first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2a_back import r2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  item_valid,
  output logic                       item_pop,
  input  wire logic [VALUE_BITS-1:0] item_value,
  input  wire logic [RADIX_W-1:0]    item_radix,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [CHAR_W-1:0]          out_char,
  output logic                       out_tlast
);

  localparam int NCHUNK    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_BITS = NCHUNK * STEP_BITS;
  localparam int CHUNK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int ADDR_W    = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [WORK_BITS-1:0] work_r;      // dividend shifting out, quotient shifting in
  logic [RADIX_W-1:0]   rem_r;
  logic [RADIX_W-1:0]   radix_r;
  logic [CHUNK_W-1:0]   chunk_r;
  logic [ADDR_W-1:0]    idx_r;       // stack write index, then read pointer
  logic                 out_valid_r;
  logic                 out_last_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [CHAR_W-1:0]    stack_mem [VALUE_BITS];

  logic [WORK_BITS-1:0] work_step;
  logic [RADIX_W:0]     rem_step;
  logic                 div_done;
  logic                 quot_zero;
  logic                 push_en;
  logic                 out_load;

  // restoring division, STEP_BITS bits per cycle; remainder stays below radix
  always_comb begin
    logic [RADIX_W:0] rem_sh;
    work_step = work_r;
    rem_step  = {1'b0, rem_r};
    for (int i = 0; i < STEP_BITS; i++) begin
      rem_sh    = {rem_step[RADIX_W-1:0], work_step[WORK_BITS-1]};
      work_step = {work_step[WORK_BITS-2:0], 1'b0};
      if (rem_sh >= {1'b0, radix_r}) begin
        rem_sh       = rem_sh - {1'b0, radix_r};
        work_step[0] = 1'b1;
      end
      rem_step = rem_sh;
    end
  end

  assign div_done  = (chunk_r == CHUNK_W'(NCHUNK - 1));
  assign quot_zero = (work_step == '0);
  assign push_en   = (state_r == S_DIV) && div_done;
  assign item_pop  = (state_r == S_IDLE) && item_valid;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            work_r  <= WORK_BITS'(item_value);
            radix_r <= item_radix;
            rem_r   <= '0;
            chunk_r <= '0;
            idx_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          work_r <= work_step;
          if (div_done) begin
            // quotient is now in work_r; start the next digit from a clean remainder
            rem_r   <= '0;
            chunk_r <= '0;
            if (quot_zero) begin
              state_r <= S_EMIT;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            rem_r   <= rem_step[RADIX_W-1:0];
            chunk_r <= chunk_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (idx_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_last_r  <= (idx_r == '0);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // digit stack: the read register doubles as the output data register
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[idx_r] <= digit_char_of(rem_step[RADIX_W-1:0]);
    end
    if (out_load) begin
      out_char_r <= stack_mem[idx_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_char   = out_char_r;

endmodule

`default_nettype wire

// ===== sv/radix_to_ascii_digits_core.sv =====
// ---------------------------------------------------------------------------
// radix_to_ascii_digits_core: unsigned integer to ASCII digits, radix 2..36
// Front clamps the radix, a two-entry queue buffers items, the back end
// divides and returns the digits most significant first.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: value[31:0], radix[37:32]
//  out_    | out | out_tvalid/tready  | tdata: digit_char[6:0]; tlast: last_digit
//
//  The shared divider resolves each digit STEP_BITS quotient bits at a time,
//  and the digits are then read back off the digit stack, most significant
//  first, before the next item is started. Reset is synchronous, active low,
//  and clears the control state only. The queue keeps taking items while the
//  divider works, as long as it has room, and the output register holds a
//  digit until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_to_ascii_digits_core import r2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], radix[37:32], zero[39:38]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // digit_char[6:0], zero[7]
  output logic             out_tlast   // last_digit
);

  localparam int ITEM_W = VALUE_BITS + RADIX_W;

  logic                  q_push;
  logic                  q_ready;
  logic                  q_pop;
  logic                  q_valid;
  logic [VALUE_BITS-1:0] f_value;
  logic [RADIX_W-1:0]    f_radix;
  logic [ITEM_W-1:0]     q_dout;
  logic [CHAR_W-1:0]     out_char;

  r2a_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata[IN_VALUE_W-1:0]),
    .in_radix  (in_tdata[IN_VALUE_W+RADIX_W-1:IN_VALUE_W]),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_value   (f_value),
    .q_radix   (f_radix)
  );

  r2a_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .din        ({f_radix, f_value}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .dout       (q_dout)
  );

  r2a_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_pop   (q_pop),
    .item_value (q_dout[VALUE_BITS-1:0]),
    .item_radix (q_dout[ITEM_W-1:VALUE_BITS]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

  // the back end only pops when the queue holds an item
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("digit converter popped an empty queue");

  // every digit presented is a legal ASCII digit or capital letter
  a_digit_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[6:0] >= CHAR_ZERO && out_tdata[6:0] <= 7'd57) ||
                    (out_tdata[6:0] >= 7'd65 && out_tdata[6:0] <= CHAR_TOP)))
    else $error("output digit outside 0-9 / A-Z");

  // nothing is presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: regression bench for radix_to_ascii_digits_core
// Streams value/radix transactions into the core, predicts the ASCII digit
// sequence for each one, and checks every output transaction against it in
// order. Both channels stall in random bursts, with one long output hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import r2a_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES   = 200;   // wait after the last expected digit has arrived
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;     // value[31:0], radix[37:32], zero[39:38]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;           // digit_char[6:0], zero[7]
  logic        out_tlast;           // last_digit

  digit_t digits_due[$];
  int     fail_cnt    = 0;
  int     idle_cycles = 0;
  int     hold_req    = 0;
  bit     idle_on     = 1'b1;

  radix_to_ascii_digits_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Digits of one number, most significant first, appended to digits_due
  function automatic void predict_digits(input logic [31:0] value,
                                         input logic [RADIX_W-1:0] radix);
    logic [RADIX_W-1:0] rem [32];
    logic [31:0]        rest;
    logic [RADIX_W-1:0] base;
    digit_t             item;
    int                 n;
    base = (radix < RADIX_MIN) ? RADIX_MIN : ((radix > RADIX_MAX) ? RADIX_MAX : radix);
    rest = value;
    n = 0;
    do begin
      rem[n] = RADIX_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      item.digit_char = (rem[k] < 10) ? CHAR_ZERO + CHAR_W'(rem[k])
                                      : CHAR_LETTER + CHAR_W'(rem[k]);
      item.last_digit = (k == 0);
      digits_due.push_back(item);
    end
  endfunction

  task automatic send_number(input logic [31:0] value, input logic [RADIX_W-1:0] radix);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, radix, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_digits(value, radix);
  endtask

  // Output side: random stall bursts, plus a long hold on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (hold - 1) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    digit_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (digits_due.size() == 0) begin
        $error("unexpected digit: digit_char %0d last_digit %0b", out_tdata[6:0], out_tlast);
        fail_cnt++;
      end else begin
        due = digits_due.pop_front();
        if (out_tdata[6:0] !== due.digit_char) begin
          $error("digit_char: expected %0d, got %0d", due.digit_char, out_tdata[6:0]);
          fail_cnt++;
        end
        if (out_tlast !== due.last_digit) begin
          $error("last_digit: expected %0b, got %0b", due.last_digit, out_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic test_extremes();
    send_number(32'd0, 6'd10);
    send_number(32'd0, 6'd2);
    send_number(32'hFFFF_FFFF, 6'd2);       // 32 digits
    send_number(32'hFFFF_FFFF, 6'd10);
    send_number(32'hFFFF_FFFF, 6'd16);
    send_number(32'hFFFF_FFFF, 6'd36);
    send_number(32'h8000_0000, 6'd2);
    send_number(32'd1, 6'd2);
    send_number(32'd35, 6'd36);             // single 'Z'
    send_number(32'd36, 6'd36);
    send_number(32'd9, 6'd10);
    send_number(32'd10, 6'd11);             // single 'A'
  endtask

  task automatic test_radix_clamp();
    send_number(32'd255, 6'd0);
    send_number(32'd255, 6'd1);
    send_number(32'd123456, 6'd37);
    send_number(32'hDEAD_BEEF, 6'd63);
    send_number(32'd0, 6'd63);
  endtask

  // Sender keeps offering while the output is held; the core must back up
  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      send_number($urandom, 6'($urandom_range(2, 5)));
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random(input int count);
    logic [31:0]        value;
    logic [RADIX_W-1:0] radix;
    longint unsigned    pw;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        radix = 6'($urandom_range(0, 63));
      end else begin
        radix = 6'($urandom_range(2, 36));
      end
      case ($urandom_range(0, 5))
        0: value = $urandom_range(0, 40);
        1: value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
        2: value = 32'd1 << $urandom_range(0, 31);
        3: begin
          // exact powers of the radix and one below them
          pw = 1;
          repeat ($urandom_range(1, 32)) begin
            if (pw * ((radix < 2) ? 2 : ((radix > 36) ? 36 : radix)) <= 64'hFFFF_FFFF)
              pw = pw * ((radix < 2) ? 2 : ((radix > 36) ? 36 : radix));
          end
          value = 32'(pw) - 32'($urandom_range(0, 1));
        end
        default: value = $urandom;
      endcase
      send_number(value, radix);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_radix_clamp();
    test_output_hold();
    test_random(200);
    idle_on = 1'b0;
    test_random(30);
    in_tvalid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
